// File: sv/ltvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvd_pkg
// shared types and constants for the length-type-value deframer
// ----------------------------------------------------------------------------
package ltvd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 31;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD_ALL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd1;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 31'd65536;

    // index of the final length byte
    localparam logic [1:0] LEN_LAST_IDX = 2'd3;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_type;
        logic              has_data;
        logic              last_of_frame;
        logic              length_error;
    } result_t;

endpackage

// File: sv/ltvd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvd_out_buf
// result register with one skid entry behind it
// ----------------------------------------------------------------------------
module ltvd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ltvd_pkg::result_t push_data,
    input  logic             out_stall,
    output logic             out_valid,
    output ltvd_pkg::result_t out_data,
    output logic             full
);
    import ltvd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // input is held off while the skid entry is full
            if (take)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

// File: sv/length_type_value_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_type_value_deframer_core
// splits a byte stream of length / type / payload frames into tagged words
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------------
//  in       sink       in_valid / in_stall  byte_in
//  out      source     out_valid/out_stall  payload_byte frame_type has_data
//                                           last_of_frame length_error
//  cfg      sink       cfg_valid/cfg_ready  cfg_index cfg_data
//
//  one input word per clock while in_stall is low; each result is registered (in
//  the skid entry if out stalls). the whole step is one pass of frame-state
//  logic into the result register, so the parsing state is the only loop
//  reset clears the frame state, the registers to discard_all=0 and
//  max_length=65536, and empties the result buffer
//  in_stall rises only when the result register and its skid entry are both
//  full; cfg_ready is always high
//
// ----------------------------------------------------------------------------
module length_type_value_deframer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // byte input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ltvd_pkg::BYTE_W-1:0]      byte_in,
    // result output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ltvd_pkg::BYTE_W-1:0]      payload_byte,
    output logic [ltvd_pkg::BYTE_W-1:0]      frame_type,
    output logic                             has_data,
    output logic                             last_of_frame,
    output logic                             length_error,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ltvd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltvd_pkg::LEN_W-1:0]       cfg_data
);
    import ltvd_pkg::*;

    // configuration
    logic             discard_all_reg;
    logic [LEN_W-1:0] max_length_reg;

    // frame state
    phase_t           phase_reg, phase_next;
    logic [1:0]       len_idx_reg, len_idx_next;
    logic [23:0]      len_asm_reg, len_asm_next;      // first three length bytes
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic [BYTE_W-1:0] held_type_reg, held_type_next;

    logic             accept;
    logic             buf_full;
    logic             push;
    result_t          res;
    result_t          out_data;
    logic [31:0]      full_len;
    logic             is_last;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_all_reg <= 1'b0;
            max_length_reg  <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISCARD_ALL: discard_all_reg <= cfg_data[0];
                REG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                default:         ;  // unknown index is ignored
            endcase
        end
    end

    // full length once the final byte arrives (little endian)
    assign full_len = {byte_in, len_asm_reg};
    assign is_last  = (remaining_reg <= LEN_W'(1));

    always_comb
    begin
        phase_next     = phase_reg;
        len_idx_next   = len_idx_reg;
        len_asm_next   = len_asm_reg;
        remaining_next = remaining_reg;
        held_type_next = held_type_reg;
        push           = 1'b0;
        res            = '0;

        if (accept && !discard_all_reg)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    held_type_next = byte_in;
                    if (remaining_reg == '0)
                    begin
                        // empty frame: one result with no data
                        phase_next        = PH_LENGTH;
                        push              = 1'b1;
                        res.frame_type    = byte_in;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    push              = 1'b1;
                    res.payload_byte  = byte_in;
                    res.frame_type    = held_type_reg;
                    res.has_data      = 1'b1;
                    res.last_of_frame = is_last;
                    if (is_last)
                    begin
                        remaining_next = '0;
                        phase_next     = PH_LENGTH;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - LEN_W'(1);
                    end
                end
                default:
                begin
                    // gathering length bytes, also the unused phase code
                    phase_next = PH_LENGTH;
                    if (len_idx_reg != LEN_LAST_IDX)
                    begin
                        case (len_idx_reg)
                            2'd0:    len_asm_next = {16'd0, byte_in};
                            2'd1:    len_asm_next[15:8]  = byte_in;
                            default: len_asm_next[23:16] = byte_in;
                        endcase
                        len_idx_next = len_idx_reg + 2'd1;
                    end
                    else
                    begin
                        len_idx_next = 2'd0;
                        if (full_len[31] || (full_len[LEN_W-1:0] > max_length_reg))
                        begin
                            // negative or oversize length: flag and resync
                            remaining_next    = '0;
                            push              = 1'b1;
                            res.last_of_frame = 1'b1;
                            res.length_error  = 1'b1;
                        end
                        else
                        begin
                            remaining_next = full_len[LEN_W-1:0];
                            phase_next     = PH_TYPE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LENGTH;
            len_idx_reg   <= 2'd0;
            len_asm_reg   <= '0;
            remaining_reg <= '0;
            held_type_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_idx_reg   <= len_idx_next;
            len_asm_reg   <= len_asm_next;
            remaining_reg <= remaining_next;
            held_type_reg <= held_type_next;
        end
    end

    ltvd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (buf_full)
    );

    assign payload_byte  = out_data.payload_byte;
    assign frame_type    = out_data.frame_type;
    assign has_data      = out_data.has_data;
    assign last_of_frame = out_data.last_of_frame;
    assign length_error  = out_data.length_error;

endmodule
